### hdl/fsp_pkg.sv
// Shared types and constants for the fixed slot pool allocator.
// No dependencies; imported by fixed_slot_pool_allocator.
package fsp_pkg;

	localparam int SLOTS = 64;
	localparam int SLOT_W = $clog2(SLOTS);
	// limit compare width: holds the slot_limit field and the slot count itself
	localparam int LIMIT_W = (SLOT_W + 1 > 7) ? SLOT_W + 1 : 7;
	localparam int COUNT_W = 7;
	localparam int STRIDE_W = 16;
	localparam int ADDR_W = 32;
	localparam int IDX_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd2;

endpackage

### hdl/fixed_slot_pool_allocator.sv
// Fixed slot pool allocator: lowest free slot grant and slot release.
// Depends on fsp_pkg for widths, status and opcode codes, register indexes.
//
// Usage: raise start with opcode and slot_index for one cycle; the request is
// taken when start is high and busy is low. busy stays low, so a request can
// be issued in every cycle. opcode allocate grants the lowest free slot below
// min(slot_limit, SLOTS); opcode free releases slot_index if it is busy and in
// range. Errors (pool full, bad free) return slot and address zero and leave
// the pool unchanged.
// A request passes the input register, the decision stage register and the
// result register; throughput is one request per cycle. The busy map and count
// are updated in the decision stage, so a request sees every earlier one.
// Results appear for exactly one cycle with done high; the receiver cannot
// stall them and nothing is buffered.
// Registers are written through cfg_valid/cfg_ready (always ready) at index
// 0 slot_limit, 1 object_bytes, 2 base_address; other indexes are ignored.
// Write them only while no request is in flight.
// Reset (arst_n low) frees every slot, clears the count and loads
// slot_limit 64, object_bytes 1, base_address 0.
module fixed_slot_pool_allocator
	import fsp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  opcode,
	input  logic [IDX_W-1:0]      slot_index,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [IDX_W-1:0]      granted_slot,
	output logic [ADDR_W-1:0]     slot_address,
	output logic [1:0]            status,
	output logic [COUNT_W-1:0]    in_use_count
);

	logic [COUNT_W-1:0]  slot_limit_q;
	logic [STRIDE_W-1:0] object_bytes_q;
	logic [ADDR_W-1:0]   base_address_q;

	logic [SLOTS-1:0]    busy_map_q;
	logic [COUNT_W-1:0]  busy_count_q;

	logic                valid_s1;
	opcode_t             opcode_s1;
	logic [IDX_W-1:0]    slot_index_s1;

	logic                valid_s2;
	logic [SLOT_W-1:0]   slot_s2;
	status_t             status_s2;
	logic [COUNT_W-1:0]  count_s2;

	logic                done_q;
	logic [IDX_W-1:0]    granted_q;
	logic [ADDR_W-1:0]   address_q;
	status_t             status_q;
	logic [COUNT_W-1:0]  count_q;

	logic [LIMIT_W-1:0]  limit;
	logic [LIMIT_W-1:0]  free_idx;
	logic [SLOTS-1:0]    free_vec;
	logic [SLOTS-1:0]    first_free;
	logic [SLOT_W-1:0]   alloc_slot;
	logic                free_hit;

	logic [SLOT_W-1:0]   dec_slot;
	status_t             dec_status;
	logic                dec_set;
	logic                dec_clear;

	logic [SLOT_W+STRIDE_W-1:0] offset;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q   <= COUNT_W'(64);
			object_bytes_q <= STRIDE_W'(1);
			base_address_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SLOT_LIMIT:   slot_limit_q   <= cfg_data[COUNT_W-1:0];
				CFG_OBJECT_BYTES: object_bytes_q <= cfg_data[STRIDE_W-1:0];
				CFG_BASE_ADDRESS: base_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			opcode_s1     <= opcode_t'(opcode);
			slot_index_s1 <= slot_index;
		end
	end

	// lowest free slot below the active limit
	always_comb begin
		limit = (LIMIT_W'(slot_limit_q) < LIMIT_W'(SLOTS)) ? LIMIT_W'(slot_limit_q)
			: LIMIT_W'(SLOTS);
		for (int s = 0; s < SLOTS; s++) begin
			free_vec[s] = !busy_map_q[s] && (LIMIT_W'(s) < limit);
		end
		// isolate the lowest set bit, then encode the one-hot word
		first_free = free_vec & (~free_vec + SLOTS'(1));
		alloc_slot = '0;
		for (int s = 0; s < SLOTS; s++) begin
			if (first_free[s]) begin
				alloc_slot = alloc_slot | SLOT_W'(s);
			end
		end
	end

	always_comb begin
		free_idx = LIMIT_W'(slot_index_s1);
		free_hit = (free_idx < limit) && busy_map_q[free_idx[SLOT_W-1:0]];
	end

	always_comb begin
		dec_slot   = '0;
		dec_status = STATUS_OK;
		dec_set    = 1'b0;
		dec_clear  = 1'b0;
		unique case (opcode_s1)
			OP_ALLOC: begin
				if (|free_vec) begin
					dec_slot = alloc_slot;
					dec_set  = valid_s1;
				end else begin
					dec_status = STATUS_FULL;
				end
			end
			OP_FREE: begin
				if (free_hit) begin
					dec_slot  = free_idx[SLOT_W-1:0];
					dec_clear = valid_s1;
				end else begin
					dec_status = STATUS_BAD_FREE;
				end
			end
			default: dec_status = STATUS_BAD_FREE;
		endcase
	end

	// pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_map_q   <= '0;
			busy_count_q <= '0;
		end else if (dec_set) begin
			busy_map_q[dec_slot] <= 1'b1;
			busy_count_q         <= busy_count_q + COUNT_W'(1);
		end else if (dec_clear) begin
			busy_map_q[dec_slot] <= 1'b0;
			busy_count_q         <= busy_count_q - COUNT_W'(1);
		end
	end

	// decision stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			slot_s2   <= dec_slot;
			status_s2 <= dec_status;
			if (dec_set) begin
				count_s2 <= busy_count_q + COUNT_W'(1);
			end else if (dec_clear) begin
				count_s2 <= busy_count_q - COUNT_W'(1);
			end else begin
				count_s2 <= busy_count_q;
			end
		end
	end

	assign offset = SLOT_W'(slot_s2) * object_bytes_q;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			granted_q <= IDX_W'(slot_s2);
			status_q  <= status_s2;
			count_q   <= count_s2;
			if (status_s2 == STATUS_OK) begin
				address_q <= base_address_q + ADDR_W'(offset);
			end else begin
				address_q <= '0;
			end
		end
	end

	assign done         = done_q;
	assign granted_slot = granted_q;
	assign slot_address = address_q;
	assign status       = status_q;
	assign in_use_count = count_q;

endmodule
